/* design/alfp_pkg.sv */
// Shared types, character codes and the mnemonic table of the assembly line parser.
`default_nettype none

package alfp_pkg;

    // Character codes that steer the parse.
    localparam logic [7:0] CH_SPACE   = 8'd32;
    localparam logic [7:0] CH_STAR    = 8'd42;
    localparam logic [7:0] CH_COMMA   = 8'd44;
    localparam logic [7:0] CH_OPEN    = 8'd40;
    localparam logic [7:0] CH_MINUS   = 8'd45;
    localparam logic [7:0] CH_DIGIT_0 = 8'd48;
    localparam logic [7:0] CH_DIGIT_9 = 8'd57;
    localparam logic [7:0] CH_UPPER_A = 8'd65;
    localparam logic [7:0] CH_UPPER_Z = 8'd90;

    // Mnemonic buffer limits.
    localparam logic [2:0] MNEM_MAX_LEN  = 3'd4;
    localparam logic [2:0] MNEM_TOO_LONG = 3'd5;

    // Operand slots; the index saturates one past the last slot.
    localparam logic [1:0] OP_SLOTS = 2'd3;

    // Entries in the queue between front and back.
    localparam int QUEUE_DEPTH = 2;

    localparam int OPC_COUNT = 17;

    // Mnemonic text, first letter in the low byte, with its length.
    localparam logic [31:0] MNEM_TEXT [OPC_COUNT] = '{
        32'h544C4148, 32'h00004E49, 32'h0054554F, 32'h00444441,
        32'h00425553, 32'h004C554D, 32'h00564944, 32'h0000444C,
        32'h0041444C, 32'h0043444C, 32'h00005453, 32'h00544C4A,
        32'h00454C4A, 32'h0045474A, 32'h0054474A, 32'h0051454A,
        32'h00454E4A
    };
    localparam logic [2:0] MNEM_LEN [OPC_COUNT] = '{
        3'd4, 3'd2, 3'd3, 3'd3, 3'd3, 3'd3, 3'd3, 3'd2, 3'd3,
        3'd3, 3'd2, 3'd3, 3'd3, 3'd3, 3'd3, 3'd3, 3'd3
    };

    typedef enum logic [1:0] {
        ERR_OK      = 2'd0,
        ERR_MNEM    = 2'd1,
        ERR_MISSING = 2'd2,
        ERR_RANGE   = 2'd3
    } t_err;

    // Per-operand status bits.
    typedef struct packed {
        logic stop;
        logic neg;
        logic digit;
    } t_op_flags;

    // Status of one finished line, handed from front to back.
    typedef struct packed {
        logic [2:0]          mnem_len;
        logic                line_digit;
        t_op_flags [2:0]     op;
    } t_line_flags;

    typedef struct packed {
        logic       hit;
        logic [4:0] code;
    } t_lookup;

    // Input item: one character of the line.
    typedef struct packed {
        logic [7:0] character;
        logic       line_end;
    } t_char_item;

    // Result item: one decoded instruction.
    typedef struct packed {
        logic [9:0]         line_number;
        logic [4:0]         opcode;
        logic signed [15:0] first_operand;
        logic signed [15:0] second_operand;
        logic signed [15:0] third_operand;
        logic [1:0]         error_code;
    } t_instr_item;

    // Matches the collected mnemonic against the table.
    function automatic t_lookup opcode_lookup(input logic [31:0] text, input logic [2:0] len);
        t_lookup res;
        res = '0;
        for (int k = 0; k < OPC_COUNT; k++) begin
            if (len == MNEM_LEN[k] && text == MNEM_TEXT[k]) begin
                res.hit  = 1'b1;
                res.code = 5'(k);
            end
        end
        return res;
    endfunction

endpackage

`default_nettype wire

/* design/alfp_stream_if.sv */
// Valid/ready channel carrying one payload item per handshake.
`default_nettype none

interface alfp_stream_if #(
    parameter type t_payload = logic
) ();
    logic     valid;
    logic     ready;
    t_payload data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

/* design/alfp_queue.sv */
// Two-entry queue that decouples the character front end from the decode back end.
`default_nettype none

module alfp_queue #(
    parameter int WIDTH = 8
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_push,
    input  wire logic [WIDTH-1:0] i_data,
    input  wire logic             i_pop,
    output logic                  o_full,
    output logic                  o_empty,
    output logic [WIDTH-1:0]      o_data
);
    import alfp_pkg::*;

    localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    logic [WIDTH-1:0] r_store [QUEUE_DEPTH];
    logic [PW-1:0]    r_wr_ptr, n_wr_ptr;
    logic [PW-1:0]    r_rd_ptr, n_rd_ptr;
    logic [CW-1:0]    r_count, n_count;

    assign o_full  = (r_count == CW'(QUEUE_DEPTH));
    assign o_empty = (r_count == '0);
    assign o_data  = r_store[r_rd_ptr];

    // Pointer and fill count updates, wrapping at the queue depth.
    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (i_push) begin
            n_wr_ptr = (r_wr_ptr == PW'(QUEUE_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (i_pop) begin
            n_rd_ptr = (r_rd_ptr == PW'(QUEUE_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        if (i_push && !i_pop) begin
            n_count = r_count + 1'b1;
        end else if (i_pop && !i_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    // Entry storage needs no reset.
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_store[r_wr_ptr] <= i_data;
        end
    end

endmodule

`default_nettype wire

/* design/alfp_front.sv */
// Front end: takes one character per cycle while the queue has room, building the current line's fields.
`default_nettype none

module alfp_front #(
    parameter int IMEM_DEPTH   = 1024,
    parameter int OPERAND_BITS = 16
) (
    input  wire logic                                   i_clk,
    input  wire logic                                   i_rst_n,
    alfp_stream_if.sink                                 i_line,
    input  wire logic                                   i_full,
    output logic                                        o_push,
    output logic [$clog2(IMEM_DEPTH+1)-1:0]             o_acc,
    output logic [31:0]                                 o_mnem,
    output alfp_pkg::t_line_flags                       o_flags,
    output logic [2:0][OPERAND_BITS-1:0]                o_mag
);
    import alfp_pkg::*;

    localparam int LA_W = $clog2(IMEM_DEPTH + 1);
    localparam int OB   = OPERAND_BITS;
    localparam logic [OB-1:0] MAG_CAP = {1'b1, {(OB-2){1'b0}}, 1'b1};

    logic                    r_nonspace, n_nonspace;
    logic                    r_comment, n_comment;
    logic                    r_line_digit, n_line_digit;
    logic [LA_W-1:0]         r_acc, n_acc;
    logic [31:0]             r_mnem, n_mnem;
    logic [2:0]              r_mlen, n_mlen;
    logic                    r_letter, n_letter;
    logic                    r_phase, n_phase;
    logic [1:0]              r_opidx, n_opidx;
    logic [2:0][OB-1:0]      r_mag, n_mag;
    t_op_flags [2:0]         r_flags, n_flags;

    logic                    fire;
    logic                    last;
    logic [7:0]              ch;
    logic                    is_digit;
    logic                    is_upper;
    logic [LA_W+3:0]         acc_prod;
    logic [OB-1:0]           sel_mag;
    t_op_flags               sel_flags;
    logic [OB+3:0]           mag_prod;
    logic [OB-1:0]           upd_mag;
    t_op_flags               upd_flags;

    assign ch       = i_line.data.character;
    assign last     = i_line.data.line_end;
    assign fire     = i_line.valid && i_line.ready;
    assign is_digit = (ch >= CH_DIGIT_0) && (ch <= CH_DIGIT_9);
    assign is_upper = (ch >= CH_UPPER_A) && (ch <= CH_UPPER_Z);

    // A line can always finish while the queue has room.
    assign i_line.ready = !i_full;

    // Separate multiply-by-ten steps for the line number and the active operand.
    assign acc_prod = ({4'b0, r_acc} * (LA_W+4)'(10)) + (LA_W+4)'(ch[3:0]);
    assign mag_prod = ({4'b0, sel_mag} * (OB+4)'(10)) + (OB+4)'(ch[3:0]);

    // Pick the operand slot that the index points at.
    always_comb begin
        sel_mag   = '0;
        sel_flags = '0;
        for (int k = 0; k < 3; k++) begin
            if (r_opidx == 2'(k)) begin
                sel_mag   = r_mag[k];
                sel_flags = r_flags[k];
            end
        end
    end

    // Next operand value and flags for a digit or minus sign.
    always_comb begin
        upd_mag   = sel_mag;
        upd_flags = sel_flags;
        if (ch == CH_MINUS) begin
            if (sel_flags == '0) begin
                upd_flags.neg = 1'b1;
            end else begin
                upd_flags.stop = 1'b1;
            end
        end else if (!sel_flags.stop) begin
            upd_flags.digit = 1'b1;
            upd_mag = (mag_prod > {4'b0, MAG_CAP}) ? MAG_CAP : mag_prod[OB-1:0];
        end
    end

    // Line state after the current character.
    always_comb begin
        n_nonspace   = r_nonspace;
        n_comment    = r_comment;
        n_line_digit = r_line_digit;
        n_acc        = r_acc;
        n_mnem       = r_mnem;
        n_mlen       = r_mlen;
        n_letter     = r_letter;
        n_phase      = r_phase;
        n_opidx      = r_opidx;
        n_mag        = r_mag;
        n_flags      = r_flags;

        if (!r_nonspace && ch != CH_SPACE) begin
            n_nonspace = 1'b1;
            if (ch == CH_STAR) begin
                n_comment = 1'b1;
            end
        end

        if (is_digit && !r_letter) begin
            n_acc = (acc_prod > (LA_W+4)'(IMEM_DEPTH)) ? LA_W'(IMEM_DEPTH)
                                                      : acc_prod[LA_W-1:0];
            n_line_digit = 1'b1;
        end else begin
            if (is_upper && !r_phase) begin
                if (r_mlen < MNEM_MAX_LEN) begin
                    for (int k = 0; k < 4; k++) begin
                        if (r_mlen == 3'(k)) begin
                            n_mnem[8*k +: 8] = ch;
                        end
                    end
                    n_mlen = r_mlen + 3'd1;
                end else begin
                    n_mlen = MNEM_TOO_LONG;
                end
                n_letter = 1'b1;
            end
            if (is_digit || ch == CH_COMMA || ch == CH_OPEN || ch == CH_MINUS) begin
                n_phase = 1'b1;
                if (ch == CH_COMMA || ch == CH_OPEN) begin
                    if (r_opidx < OP_SLOTS) begin
                        n_opidx = r_opidx + 2'd1;
                    end
                end else begin
                    for (int k = 0; k < 3; k++) begin
                        if (r_opidx == 2'(k)) begin
                            n_mag[k]   = upd_mag;
                            n_flags[k] = upd_flags;
                        end
                    end
                end
            end
        end
    end

    // Hand a finished line to the queue unless it is blank or a comment.
    always_comb begin
        o_push              = fire && last && n_nonspace && !n_comment;
        o_acc               = n_acc;
        o_mnem              = n_mnem;
        o_mag               = n_mag;
        o_flags.mnem_len    = n_mlen;
        o_flags.line_digit  = n_line_digit;
        o_flags.op          = n_flags;
    end

    // Line state registers, cleared at reset and after every line end.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (fire && last)) begin
            r_nonspace   <= 1'b0;
            r_comment    <= 1'b0;
            r_line_digit <= 1'b0;
            r_acc        <= '0;
            r_mnem       <= '0;
            r_mlen       <= '0;
            r_letter     <= 1'b0;
            r_phase      <= 1'b0;
            r_opidx      <= '0;
            r_mag        <= '0;
            r_flags      <= '0;
        end else if (fire) begin
            r_nonspace   <= n_nonspace;
            r_comment    <= n_comment;
            r_line_digit <= n_line_digit;
            r_acc        <= n_acc;
            r_mnem       <= n_mnem;
            r_mlen       <= n_mlen;
            r_letter     <= n_letter;
            r_phase      <= n_phase;
            r_opidx      <= n_opidx;
            r_mag        <= n_mag;
            r_flags      <= n_flags;
        end
    end

endmodule

`default_nettype wire

/* design/alfp_back.sv */
// Back end: decodes a finished line into an instruction and holds it in the output register.
`default_nettype none

module alfp_back #(
    parameter int IMEM_DEPTH   = 1024,
    parameter int OPERAND_BITS = 16
) (
    input  wire logic                                   i_clk,
    input  wire logic                                   i_rst_n,
    input  wire logic                                   i_rec_valid,
    output logic                                        o_rec_pop,
    input  wire logic [$clog2(IMEM_DEPTH+1)-1:0]        i_acc,
    input  wire logic [31:0]                            i_mnem,
    input  wire alfp_pkg::t_line_flags                  i_flags,
    input  wire logic [2:0][OPERAND_BITS-1:0]           i_mag,
    alfp_stream_if.source                               o_instr
);
    import alfp_pkg::*;

    localparam int LA_W = $clog2(IMEM_DEPTH + 1);
    localparam int OB   = OPERAND_BITS;
    localparam int VW   = OB + 16;
    localparam logic [OB-1:0] LIM_POS = {1'b0, {(OB-1){1'b1}}};
    localparam logic [OB-1:0] LIM_NEG = {1'b1, {(OB-1){1'b0}}};

    logic            r_valid;
    t_instr_item     r_item, n_item;
    t_lookup         lk;
    t_err            err;
    logic [LA_W-1:0] acc_sat;
    logic [OB-1:0]   m;
    logic [VW-1:0]   wide;
    logic [2:0][15:0] ops;

    assign lk        = opcode_lookup(i_mnem, i_flags.mnem_len);
    assign o_rec_pop = i_rec_valid && (!r_valid || o_instr.ready);
    assign acc_sat   = (i_acc >= LA_W'(IMEM_DEPTH)) ? LA_W'(IMEM_DEPTH - 1) : i_acc;

    // Error priority: unknown mnemonic, then missing field, then range.
    always_comb begin
        err  = ERR_OK;
        ops  = '0;
        m    = '0;
        wide = '0;
        if (!lk.hit) begin
            err = ERR_MNEM;
        end else if (!i_flags.line_digit || !i_flags.op[0].digit ||
                     !i_flags.op[1].digit || !i_flags.op[2].digit) begin
            err = ERR_MISSING;
        end else if (i_acc >= LA_W'(IMEM_DEPTH)) begin
            err = ERR_RANGE;
        end
        for (int k = 0; k < 3; k++) begin
            if (i_flags.op[k].digit) begin
                m = i_mag[k];
                if (i_flags.op[k].neg) begin
                    if (m > LIM_NEG) begin
                        m = LIM_NEG;
                        if (err == ERR_OK) begin
                            err = ERR_RANGE;
                        end
                    end
                    wide = '0 - VW'(m);
                end else begin
                    if (m > LIM_POS) begin
                        m = LIM_POS;
                        if (err == ERR_OK) begin
                            err = ERR_RANGE;
                        end
                    end
                    wide = VW'(m);
                end
                ops[k] = wide[15:0];
            end
        end
    end

    // Result fields, cut to the widths of the output item.
    always_comb begin
        n_item.line_number    = 10'(acc_sat);
        n_item.opcode         = lk.hit ? lk.code : 5'd0;
        n_item.first_operand  = ops[0];
        n_item.second_operand = ops[1];
        n_item.third_operand  = ops[2];
        n_item.error_code     = err;
    end

    // Output register: refilled whenever it is empty or being taken.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_rec_pop) begin
            r_valid <= 1'b1;
        end else if (o_instr.ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_rec_pop) begin
            r_item <= n_item;
        end
    end

    assign o_instr.valid = r_valid;
    assign o_instr.data  = r_item;

endmodule

`default_nettype wire

/* design/assembly_line_field_parser_top.sv */
// Top level of the assembly line parser: front end, line queue and decode back end.
//
//   Channel   Dir  Modport  Payload        Handshake
//   i_line    in   sink     t_char_item    valid/ready, one character per item
//   o_instr   out  source   t_instr_item   valid/ready, one instruction per kept line
//
// One character is taken every cycle; ready falls only while the two-entry line queue is full.
// A kept line is pushed into the queue as its last character is taken, then passes through the
// opcode table and saturation logic into the output register.
// Blank and comment lines leave nothing in the queue. Reset is synchronous and active low;
// it clears the line state, the queue pointers and the output valid flag.
`default_nettype none

module assembly_line_field_parser_top #(
    parameter int IMEM_DEPTH   = 1024,
    parameter int OPERAND_BITS = 16
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    alfp_stream_if.sink     i_line,
    alfp_stream_if.source   o_instr
);
    import alfp_pkg::*;

    localparam int LA_W  = $clog2(IMEM_DEPTH + 1);
    localparam int OB    = OPERAND_BITS;
    localparam int FL_W  = $bits(t_line_flags);
    localparam int REC_W = LA_W + 32 + FL_W + 3 * OB;

    logic                q_push;
    logic                q_pop;
    logic                q_full;
    logic                q_empty;
    logic [REC_W-1:0]    q_in;
    logic [REC_W-1:0]    q_out;

    logic [LA_W-1:0]     f_acc, b_acc;
    logic [31:0]         f_mnem, b_mnem;
    t_line_flags         f_flags, b_flags;
    logic [2:0][OB-1:0]  f_mag, b_mag;

    // Character front end.
    alfp_front #(
        .IMEM_DEPTH   (IMEM_DEPTH),
        .OPERAND_BITS (OPERAND_BITS)
    ) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_line  (i_line),
        .i_full  (q_full),
        .o_push  (q_push),
        .o_acc   (f_acc),
        .o_mnem  (f_mnem),
        .o_flags (f_flags),
        .o_mag   (f_mag)
    );

    // Finished lines waiting for decode.
    assign q_in = {f_acc, f_mnem, f_flags, f_mag};

    alfp_queue #(
        .WIDTH (REC_W)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_data  (q_in),
        .i_pop   (q_pop),
        .o_full  (q_full),
        .o_empty (q_empty),
        .o_data  (q_out)
    );

    assign {b_acc, b_mnem, b_flags, b_mag} = q_out;

    // Decode back end with the output register.
    alfp_back #(
        .IMEM_DEPTH   (IMEM_DEPTH),
        .OPERAND_BITS (OPERAND_BITS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_rec_valid (!q_empty),
        .o_rec_pop   (q_pop),
        .i_acc       (b_acc),
        .i_mnem      (b_mnem),
        .i_flags     (b_flags),
        .i_mag       (b_mag),
        .o_instr     (o_instr)
    );

`ifndef ASSERT_OFF
    // A line is never written into a full queue.
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(q_push && q_full))
        else $error("line queue written while full");

    // The back end only takes a line that is present.
    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_pop |-> !q_empty)
        else $error("line queue read while empty");

    // An unknown mnemonic always reports opcode zero.
    a_unknown_opcode: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_instr.valid && o_instr.data.error_code == ERR_MNEM) |-> (o_instr.data.opcode == 5'd0))
        else $error("unknown mnemonic with nonzero opcode");

    // A line taken from the queue shows up on the output in the next cycle.
    a_pop_to_output: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_pop |=> o_instr.valid)
        else $error("decoded line missing from output register");
`endif

endmodule

`default_nettype wire

/* dv/alfp_tb_pkg.sv */
// Opcode names and mnemonic spellings shared by the line stimulus and the instruction checker.
package alfp_tb_pkg;

    // Opcodes in table order; the position is the opcode value.
    typedef enum int {
        OPC_HALT, OPC_IN, OPC_OUT, OPC_ADD, OPC_SUB, OPC_MUL, OPC_DIV, OPC_LD, OPC_LDA,
        OPC_LDC, OPC_ST, OPC_JLT, OPC_JLE, OPC_JGE, OPC_JGT, OPC_JEQ, OPC_JNE
    } t_opcode;

    localparam int MNEMONIC_COUNT = 17;

    // An unknown mnemonic reports the opcode field as zero.
    localparam logic [4:0] OPCODE_UNKNOWN = 5'(OPC_HALT);

    function automatic string mnemonic_text(t_opcode op);
        case (op)
            OPC_HALT: return "HALT";
            OPC_IN:   return "IN";
            OPC_OUT:  return "OUT";
            OPC_ADD:  return "ADD";
            OPC_SUB:  return "SUB";
            OPC_MUL:  return "MUL";
            OPC_DIV:  return "DIV";
            OPC_LD:   return "LD";
            OPC_LDA:  return "LDA";
            OPC_LDC:  return "LDC";
            OPC_ST:   return "ST";
            OPC_JLT:  return "JLT";
            OPC_JLE:  return "JLE";
            OPC_JGE:  return "JGE";
            OPC_JGT:  return "JGT";
            OPC_JEQ:  return "JEQ";
            OPC_JNE:  return "JNE";
            default:  return "";
        endcase
    endfunction

endpackage

/* dv/alfp_line_checker.sv */
// Watches both channels of the line parser, predicts each decoded instruction and compares it.
module alfp_line_checker
    import alfp_pkg::*;
    import alfp_tb_pkg::*;
#(
    parameter int IMEM_DEPTH   = 1024,
    parameter int OPERAND_BITS = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_line_valid,
    input  logic        i_line_ready,
    input  t_char_item  i_line_item,
    input  logic        i_instr_valid,
    input  logic        i_instr_ready,
    input  t_instr_item i_instr_item,
    output int          o_mismatches,
    output int          o_waiting,
    output int          o_checked
);

    localparam int OPERANDS      = 3;
    localparam int MNEM_LETTERS  = 4;
    localparam int MAG_CEILING   = (1 << (OPERAND_BITS - 1)) + 1;
    localparam int POS_LIMIT     = (1 << (OPERAND_BITS - 1)) - 1;
    localparam int NEG_LIMIT     = 1 << (OPERAND_BITS - 1);

    // Running view of the line being received.
    int          line_acc;
    logic [31:0] mnem_word;
    int          mnem_len;
    bit          letter_seen;
    bit          operand_phase;
    int          slot;
    int          op_mag [OPERANDS];
    bit          op_digit [OPERANDS];
    bit          op_neg [OPERANDS];
    bit          op_stop [OPERANDS];
    bit          nonspace_seen;
    bit          comment_line;
    bit          number_seen;

    t_instr_item expected_instrs [$];
    int          mismatches = 0;
    int          checked = 0;

    function automatic void clear_line();
        line_acc      = 0;
        mnem_word     = '0;
        mnem_len      = 0;
        letter_seen   = 1'b0;
        operand_phase = 1'b0;
        slot          = 0;
        nonspace_seen = 1'b0;
        comment_line  = 1'b0;
        number_seen   = 1'b0;
        for (int k = 0; k < OPERANDS; k++) begin
            op_mag[k]   = 0;
            op_digit[k] = 1'b0;
            op_neg[k]   = 1'b0;
            op_stop[k]  = 1'b0;
        end
    endfunction

    function automatic logic [31:0] spelled_word(string s);
        logic [31:0] w;
        w = '0;
        for (int j = 0; j < s.len(); j++)
            w[8*j +: 8] = s[j];
        return w;
    endfunction

    // A minus only signs an untouched operand; any later minus ends it.
    function automatic void operand_char(logic [7:0] c, int digit_val);
        int grown;
        if (slot >= OPERANDS)
            return;
        if (c == CH_MINUS) begin
            if (!op_digit[slot] && !op_neg[slot] && !op_stop[slot])
                op_neg[slot] = 1'b1;
            else
                op_stop[slot] = 1'b1;
        end else if (!op_stop[slot]) begin
            grown = op_mag[slot] * 10 + digit_val;
            op_digit[slot] = 1'b1;
            op_mag[slot] = (grown > MAG_CEILING) ? MAG_CEILING : grown;
        end
    endfunction

    // Decodes the finished line into the instruction it should produce.
    function automatic t_instr_item decoded_line();
        t_instr_item r;
        t_err        err;
        int          code;
        int          m;
        string       spell;
        logic [15:0] ops [OPERANDS];
        code = -1;
        for (int k = 0; k < MNEMONIC_COUNT; k++) begin
            spell = mnemonic_text(t_opcode'(k));
            if (mnem_len == spell.len() && mnem_word == spelled_word(spell))
                code = k;
        end
        err = ERR_OK;
        if (code < 0)
            err = ERR_MNEM;
        else if (!number_seen || !op_digit[0] || !op_digit[1] || !op_digit[2])
            err = ERR_MISSING;
        else if (line_acc >= IMEM_DEPTH)
            err = ERR_RANGE;
        // Operands saturate to the signed range; overflow is reported unless
        // something more serious was found first.
        for (int k = 0; k < OPERANDS; k++) begin
            m = op_mag[k];
            if (!op_digit[k]) begin
                ops[k] = '0;
            end else if (op_neg[k]) begin
                if (m > NEG_LIMIT) begin
                    m = NEG_LIMIT;
                    if (err == ERR_OK)
                        err = ERR_RANGE;
                end
                ops[k] = 16'(-m);
            end else begin
                if (m > POS_LIMIT) begin
                    m = POS_LIMIT;
                    if (err == ERR_OK)
                        err = ERR_RANGE;
                end
                ops[k] = 16'(m);
            end
        end
        r.line_number    = (line_acc >= IMEM_DEPTH) ? 10'(IMEM_DEPTH - 1) : 10'(line_acc);
        r.opcode         = (code < 0) ? OPCODE_UNKNOWN : 5'(code);
        r.first_operand  = ops[0];
        r.second_operand = ops[1];
        r.third_operand  = ops[2];
        r.error_code     = err;
        return r;
    endfunction

    // Advances the line view by one accepted character item.
    function automatic void take_char(t_char_item it);
        logic [7:0] c;
        bit         is_digit;
        bit         is_upper;
        int         digit_val;
        int         grown;
        c         = it.character;
        is_digit  = (c >= CH_DIGIT_0) && (c <= CH_DIGIT_9);
        is_upper  = (c >= CH_UPPER_A) && (c <= CH_UPPER_Z);
        digit_val = int'(c) - int'(CH_DIGIT_0);
        if (!nonspace_seen && c != CH_SPACE) begin
            nonspace_seen = 1'b1;
            comment_line  = (c == CH_STAR);
        end
        if (is_digit && !letter_seen) begin
            // Leading digits always belong to the line number.
            grown = line_acc * 10 + digit_val;
            line_acc = (grown > IMEM_DEPTH) ? IMEM_DEPTH : grown;
            number_seen = 1'b1;
        end else begin
            if (is_upper && !operand_phase) begin
                if (mnem_len < MNEM_LETTERS) begin
                    mnem_word[8*mnem_len +: 8] = c;
                    mnem_len++;
                end else begin
                    mnem_len = MNEM_LETTERS + 1;
                end
                letter_seen = 1'b1;
            end
            if ((is_digit && letter_seen) || c == CH_COMMA || c == CH_OPEN || c == CH_MINUS) begin
                operand_phase = 1'b1;
                if (c == CH_COMMA || c == CH_OPEN) begin
                    if (slot < OPERANDS)
                        slot++;
                end else begin
                    operand_char(c, digit_val);
                end
            end
        end
        if (it.line_end) begin
            // Blank and comment lines give nothing but still clear the view.
            if (nonspace_seen && !comment_line)
                expected_instrs.push_back(decoded_line());
            clear_line();
        end
    endfunction

    function automatic bit field_matches(string name, longint want, longint got);
        if (want == got)
            return 1'b1;
        $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
        return 1'b0;
    endfunction

    // Prediction on accepted characters, comparison on accepted instructions.
    always @(posedge i_clk) begin : watch
        t_instr_item want;
        bit          ok;
        if (!i_rst_n) begin
            clear_line();
            expected_instrs.delete();
        end else begin
            if (i_line_valid && i_line_ready)
                take_char(i_line_item);
            if (i_instr_valid && i_instr_ready) begin
                if (expected_instrs.size() == 0) begin
                    $display("%0t: instruction item with none expected, actual line %0d opcode %0d",
                             $time, i_instr_item.line_number, i_instr_item.opcode);
                    mismatches++;
                end else begin
                    want = expected_instrs.pop_front();
                    ok = field_matches("line_number", want.line_number,
                                       i_instr_item.line_number)
                       & field_matches("opcode", want.opcode, i_instr_item.opcode)
                       & field_matches("first_operand", want.first_operand,
                                       i_instr_item.first_operand)
                       & field_matches("second_operand", want.second_operand,
                                       i_instr_item.second_operand)
                       & field_matches("third_operand", want.third_operand,
                                       i_instr_item.third_operand)
                       & field_matches("error_code", want.error_code,
                                       i_instr_item.error_code);
                    if (!ok)
                        mismatches++;
                    checked++;
                end
            end
        end
        o_mismatches <= mismatches;
        o_waiting    <= expected_instrs.size();
        o_checked    <= checked;
    end

endmodule

/* dv/tb.sv */
// Top of the line parser testbench: clock, reset, character stimulus and the verdict.
module tb;
    import alfp_pkg::*;
    import alfp_tb_pkg::*;

    // Worst case is far below this: each character can wait out an input gap
    // plus a queue held full by output stalls.
    localparam int CYCLE_LIMIT  = 400000;
    localparam int CHAR_TARGET  = 1700;
    localparam int DRAIN_CYCLES = 16;

    logic i_clk = 1'b0;
    logic i_rst_n;

    alfp_stream_if #(.t_payload(t_char_item))  line_ch ();
    alfp_stream_if #(.t_payload(t_instr_item)) instr_ch ();

    int         mismatches;
    int         waiting;
    int         checked;
    int         cycles = 0;
    int         stall_left = 0;
    int         chars_sent = 0;
    int         lines_sent = 0;
    int         random_lines = 0;
    bit         calm = 1'b0;
    bit         gaps_on = 1'b0;
    logic [7:0] line_chars [$];

    assembly_line_field_parser_top dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_line  (line_ch),
        .o_instr (instr_ch)
    );

    alfp_line_checker line_watch (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_line_valid  (line_ch.valid),
        .i_line_ready  (line_ch.ready),
        .i_line_item   (line_ch.data),
        .i_instr_valid (instr_ch.valid),
        .i_instr_ready (instr_ch.ready),
        .i_instr_item  (instr_ch.data),
        .o_mismatches  (mismatches),
        .o_waiting     (waiting),
        .o_checked     (checked)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // Guard against a hung handshake.
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("Run stopped at the cycle limit with %0d instructions still due", waiting);
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // Receiver: stalls in random bursts while gaps are enabled.
    always @(posedge i_clk) begin
        if (calm || !gaps_on) begin
            instr_ch.ready <= 1'b1;
        end else if (stall_left > 0) begin
            instr_ch.ready <= 1'b0;
            stall_left     <= stall_left - 1;
        end else if ($urandom_range(0, 9) == 0) begin
            instr_ch.ready <= 1'b0;
            stall_left     <= $urandom_range(0, 11);
        end else begin
            instr_ch.ready <= 1'b1;
        end
    end

    // Offers one character item and returns at the edge that accepts it.
    task automatic send_char(logic [7:0] c, logic last);
        if (!calm && gaps_on && $urandom_range(0, 7) == 0) begin
            line_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge i_clk);
        end
        line_ch.valid <= 1'b1;
        line_ch.data  <= '{character: c, line_end: last};
        @(posedge i_clk);
        while (!line_ch.ready) @(posedge i_clk);
        chars_sent++;
    endtask

    task automatic send_line();
        if (line_chars.size() == 0)
            line_chars.push_back(CH_SPACE);
        foreach (line_chars[i])
            send_char(line_chars[i], i == line_chars.size() - 1);
        lines_sent++;
    endtask

    function automatic void put_text(string s);
        for (int i = 0; i < s.len(); i++)
            line_chars.push_back(s[i]);
    endfunction

    task automatic send_text(string s);
        line_chars.delete();
        put_text(s);
        send_line();
    endtask

    function automatic void put_spaces(int n);
        repeat (n) line_chars.push_back(CH_SPACE);
    endfunction

    // Characters that steer the parse, plus lower case which it ignores.
    function automatic logic [7:0] role_char();
        case ($urandom_range(0, 6))
            0:       return CH_MINUS;
            1:       return CH_COMMA;
            2:       return CH_OPEN;
            3:       return CH_STAR;
            4:       return 8'($urandom_range(CH_UPPER_A, CH_UPPER_Z));
            5:       return 8'($urandom_range(CH_DIGIT_0, CH_DIGIT_9));
            default: return 8'($urandom_range(97, 122));
        endcase
    endfunction

    function automatic string number_text();
        case ($urandom_range(0, 9))
            0:       return "1023";
            1:       return $sformatf("%0d", $urandom_range(1024, 99999));
            2:       return $sformatf("%04d", $urandom_range(0, 99));
            3:       return "0";
            default: return $sformatf("%0d", $urandom_range(0, 1023));
        endcase
    endfunction

    // Mostly small values, with the signed limits and just past them often.
    function automatic string operand_text();
        case ($urandom_range(0, 11))
            0:       return "32767";
            1:       return "-32768";
            2:       return "32768";
            3:       return "-32769";
            4:       return "-0";
            5:       return $sformatf("%0d", $urandom_range(0, 99999));
            6:       return $sformatf("-%0d", $urandom_range(0, 40000));
            7:       return $sformatf("%05d", $urandom_range(0, 999));
            8:       return $sformatf("-%0d", $urandom_range(0, 9));
            default: return $sformatf("%0d", $urandom_range(0, 9));
        endcase
    endfunction

    // Well-formed line: number, mnemonic and three operands, either r,s,t or r,d(s).
    function automatic void build_instruction(t_opcode op);
        line_chars.delete();
        put_spaces($urandom_range(0, 2));
        put_text(number_text());
        put_spaces($urandom_range(0, 2));
        put_text(mnemonic_text(op));
        put_spaces($urandom_range(0, 3));
        put_text(operand_text());
        put_text(",");
        put_text(operand_text());
        if ($urandom_range(0, 1) == 1) begin
            put_text("(");
            put_text(operand_text());
            put_text(")");
        end else begin
            put_text(",");
            put_text(operand_text());
        end
    endfunction

    // Breaks a line by overwriting, dropping or inserting characters.
    function automatic void mangle_line();
        int pos;
        repeat ($urandom_range(1, 3)) begin
            pos = $urandom_range(0, line_chars.size());
            case ($urandom_range(0, 3))
                0: if (pos < line_chars.size()) line_chars[pos] = 8'($urandom_range(0, 255));
                1: if (pos < line_chars.size()) line_chars.delete(pos);
                2: line_chars.insert(pos, role_char());
                default: line_chars.insert(pos, 8'($urandom_range(0, 255)));
            endcase
        end
    endfunction

    function automatic void build_noise();
        line_chars.delete();
        repeat ($urandom_range(1, 12)) line_chars.push_back(8'($urandom_range(0, 255)));
    endfunction

    function automatic void build_comment();
        line_chars.delete();
        put_spaces($urandom_range(0, 2));
        put_text("*");
        repeat ($urandom_range(0, 10)) line_chars.push_back(role_char());
    endfunction

    initial begin
        int kind;
        line_ch.valid  <= 1'b0;
        line_ch.data   <= '0;
        i_rst_n        <= 1'b0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed lines: blank, comment, negative zero with a sign-only operand,
        // an over-long mnemonic with nothing else, and a line number past the memory.
        send_text(" ");
        send_text("*1");
        send_text("9LD-0,-,1");
        send_text("7HALTX");
        send_text("2000IN1,2,3");

        // Random lines; the first ones walk through every mnemonic in turn.
        while (chars_sent < CHAR_TARGET) begin
            kind = $urandom_range(0, 19);
            if (random_lines < MNEMONIC_COUNT) begin
                build_instruction(t_opcode'(random_lines));
            end else if (kind < 13) begin
                build_instruction(t_opcode'($urandom_range(0, MNEMONIC_COUNT - 1)));
            end else if (kind < 17) begin
                build_instruction(t_opcode'($urandom_range(0, MNEMONIC_COUNT - 1)));
                mangle_line();
            end else if (kind < 18) begin
                build_noise();
            end else if (kind < 19) begin
                build_comment();
            end else begin
                line_chars.delete();
                put_spaces($urandom_range(1, 4));
            end
            if (random_lines % 40 == 0)
                gaps_on <= ($urandom_range(0, 3) != 0);
            calm <= (chars_sent > CHAR_TARGET * 9 / 10);
            // Now and then hold the sender until the decoder has drained.
            if (random_lines % 60 == 30) begin
                line_ch.valid <= 1'b0;
                @(posedge i_clk);
                while (waiting != 0) @(posedge i_clk);
            end
            send_line();
            random_lines++;
        end

        line_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (waiting != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Sent %0d characters over %0d lines; %0d instructions were compared.",
                 chars_sent, lines_sent, checked);
        $display("Lines mixed all %0d mnemonics with broken, noise, comment and blank lines.",
                 MNEMONIC_COUNT);
        if (mismatches == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
